@@ hdl/cbse_pkg.sv @@
// ----------------------------------------------------------------------------
// cbse_pkg - shared types and constants of the cubic Bezier spline evaluator
// Transfer structs for both channels, fixed-point widths and the item codes.
// ----------------------------------------------------------------------------
package cbse_pkg;

   // fixed-point format and segment selection
   localparam int FRAC_BITS    = 16;
   localparam int NUM_SEGMENTS = 16;
   localparam int PT_W         = 20;
   localparam int SEG_W        = PT_W - FRAC_BITS;

   // point store: four banks, one per position inside a segment
   localparam int IDX_W   = 6;
   localparam int BANKS   = 4;
   localparam int ROWS    = 16;
   localparam int ROW_W   = 4;
   localparam int COORD_W = 32;

   // weight and accumulator widths
   localparam int UW      = FRAC_BITS + 1;
   localparam int WGT_W   = FRAC_BITS + 4;
   localparam int PROD_W  = COORD_W + WGT_W;
   localparam int PSUM_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int POS_W   = 32;
   localparam int TAN_W   = 48;

   // one in the fraction format
   localparam logic [UW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EVAL  = 1'b1
   } func_type;

   typedef struct packed {
      func_type                   func;
      logic [IDX_W-1:0]           point_index;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic [PT_W-1:0]            param_t;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [TAN_W-1:0] tangent_x;
      logic signed [TAN_W-1:0] tangent_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } pnt_type;

   typedef pnt_type [BANKS-1:0] seg_pts_type;

   typedef logic signed [WGT_W-1:0] wgt_type;

   typedef struct packed {
      wgt_type [BANKS-1:0] bw;
      wgt_type [BANKS-1:0] dw;
   } wgts_type;

endpackage

@@ hdl/cubic_bezier_spline_eval.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_spline_eval - cubic Bezier spline evaluator
// Control point store with a seven-stage position and tangent pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready, req_data) carries two kinds of
//   transfer. A write (func = FUNC_WRITE) stores coord_x and coord_y at
//   point_index and gives no result. An evaluate (func = FUNC_EVAL) picks
//   segment param_t[19:16], clamped to the last segment, and its fraction
//   param_t[15:0], and gives one transfer on the response channel
//   (rsp_valid, rsp_ready, rsp_data) holding position and tangent.
//   The result of an evaluate passes the seven register stages (point read,
//   squares, cubes, weights, products, pair sums, final sum) before
//   rsp_valid rises.
//   Throughput: one item per cycle while rsp_ready is held high; the four
//   points of a segment come from four banks read at once.
//   A write is visible to any evaluate item accepted after it.
//   Reset clears every pipeline valid bit; the point store is undefined until
//   written and is never cleared.
//   When the receiver stalls, the result is held in the output register,
//   empty stages behind it keep filling, and req_ready falls only once all
//   seven stages hold an item.
// ----------------------------------------------------------------------------
module cubic_bezier_spline_eval import cbse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                 st_valid, st_ready;
   seg_pts_type          st_pts;
   logic [FRAC_BITS-1:0] st_frac;

   logic        wg_valid, wg_ready;
   seg_pts_type wg_pts;
   wgts_type    wg_wgts;

   // point store and read stage
   cbse_point_store u_store (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_pts   (st_pts),
      .out_frac  (st_frac)
   );

   // Bernstein weights
   cbse_weight_gen u_wgen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid),
      .in_ready  (st_ready),
      .in_pts    (st_pts),
      .in_frac   (st_frac),
      .out_valid (wg_valid),
      .out_ready (wg_ready),
      .out_pts   (wg_pts),
      .out_wgts  (wg_wgts)
   );

   // products, sums and the output register
   cbse_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wg_valid),
      .in_ready  (wg_ready),
      .in_pts    (wg_pts),
      .in_wgts   (wg_wgts),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

@@ hdl/cbse_point_store.sv @@
// ----------------------------------------------------------------------------
// cbse_point_store - control point store and first pipeline stage
// Takes write items into four banks and reads the four points of a segment.
// ----------------------------------------------------------------------------
module cbse_point_store import cbse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  req_type              in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output seg_pts_type          out_pts,
   output logic [FRAC_BITS-1:0] out_frac
);

   pnt_type mem [BANKS][ROWS];

   logic                 vld_ff;
   seg_pts_type          pts_ff;
   logic [FRAC_BITS-1:0] frac_ff;

   logic             en;
   logic             accept;
   logic             wr;
   logic [SEG_W-1:0] seg_raw;
   logic [SEG_W-1:0] seg_sel;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;
   logic [1:0]       wr_bank;

   // advance when the stage is empty or its content moves on
   assign en     = !vld_ff || out_ready;
   assign accept = in_valid && en;
   assign wr     = accept && (in_data.func == FUNC_WRITE);

   // clamp the segment number to the last segment
   assign seg_raw = in_data.param_t[PT_W-1:FRAC_BITS];
   assign seg_sel = (int'(seg_raw) >= NUM_SEGMENTS) ? SEG_W'(NUM_SEGMENTS - 1) : seg_raw;
   assign rd_row  = ROW_W'(seg_sel);

   assign wr_bank = in_data.point_index[1:0];
   assign wr_row  = in_data.point_index[IDX_W-1:2];

   // write one point into the bank of its position in the segment
   always_ff @(posedge clock) begin
      for (int k = 0; k < BANKS; k++) begin
         if (wr && (wr_bank == 2'(k))) begin
            mem[k][wr_row] <= {in_data.coord_y, in_data.coord_x};
         end
      end
   end

   // read all four banks at the segment row
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < BANKS; k++) begin
            pts_ff[k] <= mem[k][rd_row];
         end
         frac_ff <= in_data.param_t[FRAC_BITS-1:0];
      end
   end

   // only evaluate items travel down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid && (in_data.func == FUNC_EVAL);
      end
   end

   assign in_ready  = en;
   assign out_valid = vld_ff;
   assign out_pts   = pts_ff;
   assign out_frac  = frac_ff;

   // a write transfer never produces a pipeline item
   a_write_no_item: assert property (@(posedge clock) disable iff (reset)
      (accept && (in_data.func == FUNC_WRITE)) |=> !vld_ff)
      else $error("write item entered the evaluation pipeline");

endmodule

@@ hdl/cbse_weight_gen.sv @@
// ----------------------------------------------------------------------------
// cbse_weight_gen - Bernstein weight pipeline
// Three stages: squares, cubes, then position and derivative weights.
// ----------------------------------------------------------------------------
module cbse_weight_gen import cbse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  seg_pts_type          in_pts,
   input  logic [FRAC_BITS-1:0] in_frac,
   output logic                 out_valid,
   input  logic                 out_ready,
   output seg_pts_type          out_pts,
   output wgts_type             out_wgts
);

   function automatic wgt_type sx(input logic [UW-1:0] v);
      return $signed({{(WGT_W-UW){1'b0}}, v});
   endfunction

   function automatic wgt_type tri3(input logic [UW-1:0] v);
      return sx(v) + (sx(v) <<< 1);
   endfunction

   // stage registers
   logic        v2_ff, v3_ff, v4_ff;
   seg_pts_type pts2_ff, pts3_ff, pts4_ff;
   logic [UW-1:0] s2_f_ff, s2_u_ff, s2_t2_ff, s2_u2_ff, s2_ut_ff;
   logic [UW-1:0] s3_t2_ff, s3_u2_ff, s3_ut_ff, s3_t3_ff, s3_u3_ff, s3_u2t_ff, s3_ut2_ff;
   wgts_type    wgt_ff;

   logic en2, en3, en4;

   logic [UW-1:0]   f_ext, u_ext;
   logic [2*UW-1:0] ff_p, uu_p, uf_p;
   logic [2*UW-1:0] t3_p, u3_p, u2t_p, ut2_p;
   wgts_type        wgt_in;

   logic signed [WGT_W+1:0] dsum;
   logic signed [WGT_W+1:0] bsum;

   // stall chain from the output back to the input
   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;

   // stage two: t squared, u squared, u times t
   assign f_ext = {1'b0, in_frac};
   assign u_ext = ONE_Q - f_ext;
   assign ff_p  = f_ext * f_ext;
   assign uu_p  = u_ext * u_ext;
   assign uf_p  = u_ext * f_ext;

   always_ff @(posedge clock) begin
      if (en2) begin
         pts2_ff  <= in_pts;
         s2_f_ff  <= f_ext;
         s2_u_ff  <= u_ext;
         s2_t2_ff <= ff_p[FRAC_BITS +: UW];
         s2_u2_ff <= uu_p[FRAC_BITS +: UW];
         s2_ut_ff <= uf_p[FRAC_BITS +: UW];
      end
   end

   // stage three: cubic terms
   assign t3_p  = s2_t2_ff * s2_f_ff;
   assign u3_p  = s2_u2_ff * s2_u_ff;
   assign u2t_p = s2_u2_ff * s2_f_ff;
   assign ut2_p = s2_u_ff * s2_t2_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         pts3_ff   <= pts2_ff;
         s3_t2_ff  <= s2_t2_ff;
         s3_u2_ff  <= s2_u2_ff;
         s3_ut_ff  <= s2_ut_ff;
         s3_t3_ff  <= t3_p[FRAC_BITS +: UW];
         s3_u3_ff  <= u3_p[FRAC_BITS +: UW];
         s3_u2t_ff <= u2t_p[FRAC_BITS +: UW];
         s3_ut2_ff <= ut2_p[FRAC_BITS +: UW];
      end
   end

   // stage four: position and derivative weights
   always_comb begin
      wgt_in.bw[0] = sx(s3_u3_ff);
      wgt_in.bw[1] = tri3(s3_u2t_ff);
      wgt_in.bw[2] = tri3(s3_ut2_ff);
      wgt_in.bw[3] = sx(s3_t3_ff);
      wgt_in.dw[0] = -tri3(s3_u2_ff);
      wgt_in.dw[1] = tri3(s3_u2_ff) - (tri3(s3_ut_ff) <<< 1);
      wgt_in.dw[2] = (tri3(s3_ut_ff) <<< 1) - tri3(s3_t2_ff);
      wgt_in.dw[3] = tri3(s3_t2_ff);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         pts4_ff <= pts3_ff;
         wgt_ff  <= wgt_in;
      end
   end

   // move valid bits with their data
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= in_valid;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   assign in_ready  = en2;
   assign out_valid = v4_ff;
   assign out_pts   = pts4_ff;
   assign out_wgts  = wgt_ff;

   assign dsum = (WGT_W+2)'($signed(wgt_ff.dw[0])) + (WGT_W+2)'($signed(wgt_ff.dw[1]))
               + (WGT_W+2)'($signed(wgt_ff.dw[2])) + (WGT_W+2)'($signed(wgt_ff.dw[3]));
   assign bsum = (WGT_W+2)'($signed(wgt_ff.bw[0])) + (WGT_W+2)'($signed(wgt_ff.bw[1]))
               + (WGT_W+2)'($signed(wgt_ff.bw[2])) + (WGT_W+2)'($signed(wgt_ff.bw[3]));

   // derivative weights cancel exactly
   a_dw_zero_sum: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (dsum == '0))
      else $error("derivative weights do not sum to zero");

   // position weights form a partition of one, less truncation
   a_bw_unity: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> ((bsum <= $signed({3'b0, ONE_Q})) &&
                 (bsum + 32 >= $signed({3'b0, ONE_Q}))))
      else $error("position weights out of range");

endmodule

@@ hdl/cbse_accum.sv @@
// ----------------------------------------------------------------------------
// cbse_accum - weighted point products and sums
// Multiplies points by weights, adds in a two-level tree and scales down.
// ----------------------------------------------------------------------------
module cbse_accum import cbse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  seg_pts_type in_pts,
   input  wgts_type    in_wgts,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_data
);

   logic v5_ff, v6_ff, v7_ff;
   logic signed [PROD_W-1:0] px5_ff [BANKS];
   logic signed [PROD_W-1:0] py5_ff [BANKS];
   logic signed [PROD_W-1:0] dx5_ff [BANKS];
   logic signed [PROD_W-1:0] dy5_ff [BANKS];
   logic signed [PSUM_W-1:0] px6_ff [2];
   logic signed [PSUM_W-1:0] py6_ff [2];
   logic signed [PSUM_W-1:0] dx6_ff [2];
   logic signed [PSUM_W-1:0] dy6_ff [2];
   rsp_type                  rsp_ff;

   logic en5, en6, en7;

   logic signed [PROD_W-1:0] px5_in [BANKS];
   logic signed [PROD_W-1:0] py5_in [BANKS];
   logic signed [PROD_W-1:0] dx5_in [BANKS];
   logic signed [PROD_W-1:0] dy5_in [BANKS];
   logic signed [SUM_W-1:0]  px_tot, py_tot, dx_tot, dy_tot;
   rsp_type                  rsp_in;

   // stall chain; the output register parts the result side
   assign en7 = !v7_ff || out_ready;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;

   // stage five: one product per point and weight
   always_comb begin
      for (int k = 0; k < BANKS; k++) begin
         px5_in[k] = $signed(in_pts[k].x) * $signed(in_wgts.bw[k]);
         py5_in[k] = $signed(in_pts[k].y) * $signed(in_wgts.bw[k]);
         dx5_in[k] = $signed(in_pts[k].x) * $signed(in_wgts.dw[k]);
         dy5_in[k] = $signed(in_pts[k].y) * $signed(in_wgts.dw[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         for (int k = 0; k < BANKS; k++) begin
            px5_ff[k] <= px5_in[k];
            py5_ff[k] <= py5_in[k];
            dx5_ff[k] <= dx5_in[k];
            dy5_ff[k] <= dy5_in[k];
         end
      end
   end

   // stage six: pair sums
   always_ff @(posedge clock) begin
      if (en6) begin
         for (int j = 0; j < 2; j++) begin
            px6_ff[j] <= PSUM_W'(px5_ff[2*j]) + PSUM_W'(px5_ff[2*j+1]);
            py6_ff[j] <= PSUM_W'(py5_ff[2*j]) + PSUM_W'(py5_ff[2*j+1]);
            dx6_ff[j] <= PSUM_W'(dx5_ff[2*j]) + PSUM_W'(dx5_ff[2*j+1]);
            dy6_ff[j] <= PSUM_W'(dy5_ff[2*j]) + PSUM_W'(dy5_ff[2*j+1]);
         end
      end
   end

   // stage seven: final sum, floor shift to the output format
   assign px_tot = SUM_W'(px6_ff[0]) + SUM_W'(px6_ff[1]);
   assign py_tot = SUM_W'(py6_ff[0]) + SUM_W'(py6_ff[1]);
   assign dx_tot = SUM_W'(dx6_ff[0]) + SUM_W'(dx6_ff[1]);
   assign dy_tot = SUM_W'(dy6_ff[0]) + SUM_W'(dy6_ff[1]);

   always_comb begin
      rsp_in.pos_x     = POS_W'(px_tot >>> FRAC_BITS);
      rsp_in.pos_y     = POS_W'(py_tot >>> FRAC_BITS);
      rsp_in.tangent_x = TAN_W'(dx_tot >>> FRAC_BITS);
      rsp_in.tangent_y = TAN_W'(dy_tot >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         rsp_ff <= rsp_in;
      end
   end

   // move valid bits with their data
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en5) v5_ff <= in_valid;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   assign in_ready  = en5;
   assign out_valid = v7_ff;
   assign out_data  = rsp_ff;

   // a result appears only from an item in the stage before
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(v7_ff) |-> $past(v6_ff))
      else $error("result appeared without an item behind it");

   // a full and stalled accumulator takes nothing new
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && v6_ff && v7_ff && !out_ready) |-> !in_ready)
      else $error("accumulator accepted an item while full and stalled");

endmodule
